// ----- sv/tcl_pkg.sv -----
// ----------------------------------------------------------------------------
// tcl_pkg
// Shared constants, payload types and control types of the tile map
// collision lookup block.
// ----------------------------------------------------------------------------
package tcl_pkg;

  localparam int NUM_LAYERS  = 3;
  localparam int MAX_DIM     = 64;
  localparam int TILE_W      = 16;
  localparam int TILE_H      = 16;
  localparam int MAIN_LAYER  = 1;
  localparam int TILE_COUNT  = 256;

  localparam int MASK_BYTES  = (TILE_W * TILE_H + 7) / 8;
  localparam int LAYER_CELLS = MAX_DIM * MAX_DIM;
  localparam int TILE_DEPTH  = NUM_LAYERS * LAYER_CELLS;
  localparam int MASK_DEPTH  = TILE_COUNT * MASK_BYTES;
  localparam int CLR_DEPTH   = (TILE_DEPTH > MASK_DEPTH) ? TILE_DEPTH : MASK_DEPTH;

  localparam int CFG_W       = 7;
  localparam int CFG_IDX_W   = 3;
  localparam int WRAP_W      = 3;
  localparam int LAYER_W     = 2;
  localparam int CRD_W       = 16;
  localparam int PIX_W       = 20;
  localparam int BYTE_W      = 8;
  localparam int MIDX_W      = 5;

  localparam int DIM_W       = $clog2(MAX_DIM + 1);
  localparam int CNT_W       = $clog2(CRD_W);
  localparam int TA_W        = $clog2(TILE_DEPTH);
  localparam int MA_W        = $clog2(MASK_DEPTH);
  localparam int CLR_W       = $clog2(CLR_DEPTH);
  localparam int BIT_W       = $clog2(TILE_W * TILE_H);
  localparam int MI_W        = BIT_W - 3;

  typedef enum logic [1:0] {
    KIND_SET   = 2'd0,
    KIND_GET   = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_MASK  = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_L0_W = 3'd0,
    CFG_L0_H = 3'd1,
    CFG_L1_W = 3'd2,
    CFG_L1_H = 3'd3,
    CFG_L2_W = 3'd4,
    CFG_L2_H = 3'd5,
    CFG_WRAP = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    kind_t               kind;
    logic [LAYER_W-1:0]  layer;
    logic [CRD_W-1:0]    tile_x;
    logic [CRD_W-1:0]    tile_y;
    logic [PIX_W-1:0]    pixel_x;
    logic [PIX_W-1:0]    pixel_y;
    logic [BYTE_W-1:0]   value;
    logic [BYTE_W-1:0]   mask_tile;
    logic [MIDX_W-1:0]   mask_index;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] tile_value;
    logic              solid;
  } out_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SET,
    ST_MASKW,
    ST_CHECK,
    ST_MOD,
    ST_TREAD,
    ST_TWAIT,
    ST_TILE,
    ST_MWAIT
  } state_t;

  typedef struct packed {
    logic clr_en;
    logic load;
    logic set_wr;
    logic mask_wr;
    logic mod_init;
    logic mod_step;
    logic tread;
    logic tcap;
    logic tzero;
    logic mread;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_range;
    logic wrap_ok;
    logic mod_last;
    logic is_query;
  } dp_status_t;

endpackage

// ----- sv/tilemap_collision_lookup_core.sv -----
// ----------------------------------------------------------------------------
// tilemap_collision_lookup_core
// Three-layer tile map with per-tile pixel collision masks.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the tile store (the mask
// store is initialized in the same sweep) with busy high. A transaction is
// taken when start is high and busy is low; one transaction is worked on at
// a time. A read outside a non-wrapping layer skips the tile store, and a
// wrapping layer read outside its size first computes the wrap remainder,
// one coordinate bit per cycle. The tile and mask stores are single-port-read
// RAMs with registered read data. out_valid is high for exactly one cycle
// per result; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module tilemap_collision_lookup_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  tcl_pkg::in_t                  in_data,
  output logic                          out_valid,
  output tcl_pkg::out_t                 out_data,
  input  logic                          cfg_we,
  input  logic [tcl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tcl_pkg::CFG_W-1:0]     cfg_wdata
);

  tcl_pkg::ctrl_cmd_t  cmd;
  tcl_pkg::dp_status_t status;

  tcl_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_kind (in_data.kind),
    .status  (status),
    .cmd     (cmd),
    .busy    (busy)
  );

  tcl_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result appeared without a transaction in progress");

endmodule

// ----- sv/tcl_ram.sv -----
// ----------------------------------------------------------------------------
// tcl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/tcl_ctrl.sv -----
// ----------------------------------------------------------------------------
// tcl_ctrl
// Sequencer: clearing pass after reset, then one transaction at a time: a write, or
// a read through bounds check, optional wrap remainder, tile read and query mask read.
// ----------------------------------------------------------------------------
module tcl_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  tcl_pkg::kind_t      in_kind,
  input  tcl_pkg::dp_status_t status,
  output tcl_pkg::ctrl_cmd_t  cmd,
  output logic                busy
);

  tcl_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tcl_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      tcl_pkg::ST_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (status.clr_last) begin
          state_nxt = tcl_pkg::ST_IDLE;
        end
      end
      tcl_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          unique case (in_kind)
            tcl_pkg::KIND_SET:   state_nxt = tcl_pkg::ST_SET;
            tcl_pkg::KIND_GET:   state_nxt = tcl_pkg::ST_CHECK;
            tcl_pkg::KIND_QUERY: state_nxt = tcl_pkg::ST_CHECK;
            tcl_pkg::KIND_MASK:  state_nxt = tcl_pkg::ST_MASKW;
            default:             state_nxt = tcl_pkg::ST_IDLE;
          endcase
        end
      end
      tcl_pkg::ST_SET: begin
        cmd.set_wr = 1'b1;
        state_nxt  = tcl_pkg::ST_IDLE;
      end
      tcl_pkg::ST_MASKW: begin
        cmd.mask_wr = 1'b1;
        state_nxt   = tcl_pkg::ST_IDLE;
      end
      tcl_pkg::ST_CHECK: begin
        priority if (status.in_range) begin
          state_nxt = tcl_pkg::ST_TREAD;
        end else if (status.wrap_ok) begin
          cmd.mod_init = 1'b1;
          state_nxt    = tcl_pkg::ST_MOD;
        end else begin
          cmd.tzero = 1'b1;
          state_nxt = tcl_pkg::ST_TILE;
        end
      end
      tcl_pkg::ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (status.mod_last) begin
          state_nxt = tcl_pkg::ST_TREAD;
        end
      end
      tcl_pkg::ST_TREAD: begin
        cmd.tread = 1'b1;
        state_nxt = tcl_pkg::ST_TWAIT;
      end
      tcl_pkg::ST_TWAIT: begin
        cmd.tcap  = 1'b1;
        state_nxt = tcl_pkg::ST_TILE;
      end
      tcl_pkg::ST_TILE: begin
        if (status.is_query) begin
          cmd.mread = 1'b1;
          state_nxt = tcl_pkg::ST_MWAIT;
        end else begin
          cmd.emit  = 1'b1;
          state_nxt = tcl_pkg::ST_IDLE;
        end
      end
      tcl_pkg::ST_MWAIT: begin
        cmd.emit  = 1'b1;
        state_nxt = tcl_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = tcl_pkg::ST_CLEAR;
      end
    endcase
  end

  assign busy = (state_r != tcl_pkg::ST_IDLE);

endmodule

// ----- sv/tcl_dpath.sv -----
// ----------------------------------------------------------------------------
// tcl_dpath
// Datapath: size registers, bounds check, bit-serial wrap remainders,
// tile and mask stores, clear counter and result register.
// ----------------------------------------------------------------------------
module tcl_dpath (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  tcl_pkg::in_t                           in_data,
  input  logic                                   cfg_we,
  input  logic [tcl_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [tcl_pkg::CFG_W-1:0]              cfg_wdata,
  input  tcl_pkg::ctrl_cmd_t                     cmd,
  output tcl_pkg::dp_status_t                    status,
  output logic                                   out_valid,
  output tcl_pkg::out_t                          out_data
);

  logic [tcl_pkg::CFG_W-1:0]  l0w_r, l0h_r, l1w_r, l1h_r, l2w_r, l2h_r;
  logic [tcl_pkg::WRAP_W-1:0] wrap_r;

  tcl_pkg::in_t               item_r;
  logic                       use_mod_r;
  logic [tcl_pkg::DIM_W-1:0]  rx_r, ry_r;
  logic [tcl_pkg::CRD_W-1:0]  shx_r, shy_r;
  logic [tcl_pkg::CNT_W-1:0]  cnt_r;
  logic [tcl_pkg::BYTE_W-1:0] tile_r;
  logic [tcl_pkg::CLR_W-1:0]  clr_r;
  logic                       out_valid_r;
  tcl_pkg::out_t              out_r;

  logic                       is_query;
  logic [tcl_pkg::LAYER_W-1:0] lay;
  logic [tcl_pkg::CRD_W-1:0]  cx, cy;
  logic [tcl_pkg::CFG_W-1:0]  raw_w, raw_h;
  logic [tcl_pkg::DIM_W-1:0]  dim_w, dim_h;
  logic [tcl_pkg::WRAP_W:0]   wrap_ext;
  logic                       in_range;
  logic [tcl_pkg::DIM_W:0]    tx_sh, ty_sh;
  logic [tcl_pkg::DIM_W-1:0]  rx_nxt, ry_nxt;
  logic [tcl_pkg::DIM_W-1:0]  ax, ay;
  logic [tcl_pkg::TA_W-1:0]   taddr;
  logic [tcl_pkg::BIT_W-1:0]  bit_idx;
  logic [tcl_pkg::MA_W-1:0]   maddr_rd, maddr_wr;
  logic                       mask_ok;

  logic                       t_we, m_we;
  logic [tcl_pkg::TA_W-1:0]   t_waddr;
  logic [tcl_pkg::BYTE_W-1:0] t_wdata;
  logic [tcl_pkg::MA_W-1:0]   m_waddr;
  logic [tcl_pkg::BYTE_W-1:0] m_wdata;
  logic [tcl_pkg::BYTE_W-1:0] t_rdata, m_rdata;

  function automatic logic [tcl_pkg::DIM_W-1:0] clamp_dim(input logic [tcl_pkg::CFG_W-1:0] v);
    if (int'(v) > tcl_pkg::MAX_DIM) begin
      return tcl_pkg::DIM_W'(tcl_pkg::MAX_DIM);
    end
    return tcl_pkg::DIM_W'(v);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l0w_r  <= tcl_pkg::CFG_W'(64);
      l0h_r  <= tcl_pkg::CFG_W'(64);
      l1w_r  <= tcl_pkg::CFG_W'(64);
      l1h_r  <= tcl_pkg::CFG_W'(64);
      l2w_r  <= tcl_pkg::CFG_W'(64);
      l2h_r  <= tcl_pkg::CFG_W'(64);
      wrap_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tcl_pkg::CFG_L0_W: l0w_r  <= cfg_wdata;
        tcl_pkg::CFG_L0_H: l0h_r  <= cfg_wdata;
        tcl_pkg::CFG_L1_W: l1w_r  <= cfg_wdata;
        tcl_pkg::CFG_L1_H: l1h_r  <= cfg_wdata;
        tcl_pkg::CFG_L2_W: l2w_r  <= cfg_wdata;
        tcl_pkg::CFG_L2_H: l2h_r  <= cfg_wdata;
        tcl_pkg::CFG_WRAP: wrap_r <= cfg_wdata[tcl_pkg::WRAP_W-1:0];
        default: ;
      endcase
    end
  end

  assign is_query = (item_r.kind == tcl_pkg::KIND_QUERY);
  assign lay = is_query ? tcl_pkg::LAYER_W'(tcl_pkg::MAIN_LAYER) : item_r.layer;
  assign cx  = is_query ? tcl_pkg::CRD_W'(item_r.pixel_x / tcl_pkg::TILE_W) : item_r.tile_x;
  assign cy  = is_query ? tcl_pkg::CRD_W'(item_r.pixel_y / tcl_pkg::TILE_H) : item_r.tile_y;

  always_comb begin
    unique case (lay)
      2'd0: begin raw_w = l0w_r; raw_h = l0h_r; end
      2'd1: begin raw_w = l1w_r; raw_h = l1h_r; end
      2'd2: begin raw_w = l2w_r; raw_h = l2h_r; end
      default: begin raw_w = '0; raw_h = '0; end
    endcase
  end

  assign dim_w    = (int'(lay) < tcl_pkg::NUM_LAYERS) ? clamp_dim(raw_w) : '0;
  assign dim_h    = (int'(lay) < tcl_pkg::NUM_LAYERS) ? clamp_dim(raw_h) : '0;
  assign wrap_ext = {1'b0, wrap_r};
  assign in_range = (cx < tcl_pkg::CRD_W'(dim_w)) && (cy < tcl_pkg::CRD_W'(dim_h));

  assign status.in_range = in_range;
  assign status.wrap_ok  = wrap_ext[lay] && (dim_w != '0) && (dim_h != '0);
  assign status.mod_last = (cnt_r == tcl_pkg::CNT_W'(tcl_pkg::CRD_W - 1));
  assign status.clr_last = (int'(clr_r) == tcl_pkg::CLR_DEPTH - 1);
  assign status.is_query = is_query;

  assign tx_sh  = {rx_r, shx_r[tcl_pkg::CRD_W-1]};
  assign ty_sh  = {ry_r, shy_r[tcl_pkg::CRD_W-1]};
  assign rx_nxt = (tx_sh >= (tcl_pkg::DIM_W+1)'(dim_w)) ?
                  tcl_pkg::DIM_W'(tx_sh - (tcl_pkg::DIM_W+1)'(dim_w)) : tcl_pkg::DIM_W'(tx_sh);
  assign ry_nxt = (ty_sh >= (tcl_pkg::DIM_W+1)'(dim_h)) ?
                  tcl_pkg::DIM_W'(ty_sh - (tcl_pkg::DIM_W+1)'(dim_h)) : tcl_pkg::DIM_W'(ty_sh);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
    if (cmd.mod_init) begin
      rx_r  <= '0;
      ry_r  <= '0;
      shx_r <= cx;
      shy_r <= cy;
      cnt_r <= '0;
    end else if (cmd.mod_step) begin
      rx_r  <= rx_nxt;
      ry_r  <= ry_nxt;
      shx_r <= {shx_r[tcl_pkg::CRD_W-2:0], 1'b0};
      shy_r <= {shy_r[tcl_pkg::CRD_W-2:0], 1'b0};
      cnt_r <= cnt_r + tcl_pkg::CNT_W'(1);
    end
    if (cmd.tzero) begin
      tile_r <= '0;
    end else if (cmd.tcap) begin
      tile_r <= t_rdata;
    end
    if (cmd.emit) begin
      out_r.tile_value <= tile_r;
      out_r.solid      <= is_query ? m_rdata[~bit_idx[2:0]] : 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_mod_r   <= 1'b0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        use_mod_r <= 1'b0;
      end else if (cmd.mod_init) begin
        use_mod_r <= 1'b1;
      end
      if (cmd.clr_en && !status.clr_last) begin
        clr_r <= clr_r + tcl_pkg::CLR_W'(1);
      end
      out_valid_r <= cmd.emit;
    end
  end

  assign ax    = use_mod_r ? rx_r : cx[tcl_pkg::DIM_W-1:0];
  assign ay    = use_mod_r ? ry_r : cy[tcl_pkg::DIM_W-1:0];
  assign taddr = tcl_pkg::TA_W'(lay) * tcl_pkg::TA_W'(tcl_pkg::LAYER_CELLS)
               + tcl_pkg::TA_W'(ax) * tcl_pkg::TA_W'(tcl_pkg::MAX_DIM)
               + tcl_pkg::TA_W'(ay);

  assign bit_idx  = tcl_pkg::BIT_W'(item_r.pixel_x % tcl_pkg::TILE_W)
                  + tcl_pkg::BIT_W'(item_r.pixel_y % tcl_pkg::TILE_H)
                  * tcl_pkg::BIT_W'(tcl_pkg::TILE_W);
  assign maddr_rd = tcl_pkg::MA_W'(tile_r) * tcl_pkg::MA_W'(tcl_pkg::MASK_BYTES)
                  + tcl_pkg::MA_W'(bit_idx[tcl_pkg::BIT_W-1:3]);
  assign maddr_wr = tcl_pkg::MA_W'(item_r.mask_tile) * tcl_pkg::MA_W'(tcl_pkg::MASK_BYTES)
                  + tcl_pkg::MA_W'(item_r.mask_index);
  assign mask_ok  = (int'(item_r.mask_index) < tcl_pkg::MASK_BYTES)
                  && (int'(item_r.mask_tile) < tcl_pkg::TILE_COUNT);

  assign t_we    = cmd.clr_en || (cmd.set_wr && in_range);
  assign t_waddr = cmd.clr_en ? tcl_pkg::TA_W'(clr_r) : taddr;
  assign t_wdata = cmd.clr_en ? '0 : item_r.value;

  assign m_we    = (cmd.clr_en && (int'(clr_r) < tcl_pkg::MASK_DEPTH)) || (cmd.mask_wr && mask_ok);
  assign m_waddr = cmd.clr_en ? tcl_pkg::MA_W'(clr_r) : maddr_wr;
  assign m_wdata = cmd.clr_en ? ((int'(clr_r) < tcl_pkg::MASK_BYTES) ? 8'h00 : 8'hFF)
                              : item_r.value;

  tcl_ram #(
    .WIDTH (tcl_pkg::BYTE_W),
    .DEPTH (tcl_pkg::TILE_DEPTH)
  ) u_tile_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .re    (cmd.tread),
    .raddr (taddr),
    .rdata (t_rdata)
  );

  tcl_ram #(
    .WIDTH (tcl_pkg::BYTE_W),
    .DEPTH (tcl_pkg::MASK_DEPTH)
  ) u_mask_ram (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .re    (cmd.mread),
    .raddr (maddr_rd),
    .rdata (m_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- sim/tilemap_collision_lookup_core_test.sv -----
// ----------------------------------------------------------------------------
// tilemap_collision_lookup_core_test
// Self-checking bench for the tile map collision lookup core: directed edge
// cases (layer borders, absent layer, mask bit order, wrapping reads, resize)
// followed by randomized transactions under several layer size and wrap
// settings. A behavioral map of tiles and masks predicts every read and
// query result, and each result strobe is compared in order against it.
// ----------------------------------------------------------------------------
module tilemap_collision_lookup_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [tcl_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 40;
  localparam int IDLE_PCT      = 21;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 50;
  localparam int QUIET_PHASE   = 5;

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          start     = 1'b0;
  logic                          busy;
  tcl_pkg::in_t                  in_data   = '0;
  logic                          out_valid;
  tcl_pkg::out_t                 out_data;
  logic                          cfg_we    = 1'b0;
  logic [tcl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [tcl_pkg::CFG_W-1:0]     cfg_wdata = '0;

  tilemap_collision_lookup_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  logic [tcl_pkg::BYTE_W-1:0]     tile_mem [tcl_pkg::TILE_DEPTH];
  logic [tcl_pkg::BYTE_W-1:0]     mask_mem [tcl_pkg::MASK_DEPTH];
  logic [5:0][tcl_pkg::CFG_W-1:0] layer_size;
  logic [tcl_pkg::WRAP_W-1:0]     wrap_mask;
  tcl_pkg::out_t                  pending_reads [$];
  int                             fault_count = 0;
  bit                             no_gaps = 1'b0;

  function automatic int unsigned layer_dim(int unsigned lyr, bit rows);
    logic [tcl_pkg::CFG_W-1:0] d;
    if (lyr >= tcl_pkg::NUM_LAYERS) return 0;
    d = layer_size[2 * lyr + rows];
    return (d > tcl_pkg::MAX_DIM) ? tcl_pkg::MAX_DIM : d;
  endfunction

  function automatic logic [tcl_pkg::BYTE_W-1:0] tile_at(int unsigned lyr, int unsigned x,
                                                         int unsigned y);
    int unsigned w, h;
    w = layer_dim(lyr, 1'b0);
    h = layer_dim(lyr, 1'b1);
    if (x < w && y < h)
      return tile_mem[lyr * tcl_pkg::LAYER_CELLS + x * tcl_pkg::MAX_DIM + y];
    if (w > 0 && h > 0 && wrap_mask[lyr])
      return tile_mem[lyr * tcl_pkg::LAYER_CELLS + (x % w) * tcl_pkg::MAX_DIM + (y % h)];
    return '0;
  endfunction

  function automatic void map_apply(tcl_pkg::in_t t);
    int unsigned                w, h, bitpos;
    logic [tcl_pkg::BYTE_W-1:0] mbyte;
    tcl_pkg::out_t              r;
    w = layer_dim(t.layer, 1'b0);
    h = layer_dim(t.layer, 1'b1);
    case (t.kind)
      tcl_pkg::KIND_SET: begin
        if (t.tile_x < w && t.tile_y < h)
          tile_mem[t.layer * tcl_pkg::LAYER_CELLS + t.tile_x * tcl_pkg::MAX_DIM
                   + t.tile_y] = t.value;
      end
      tcl_pkg::KIND_GET: begin
        r.tile_value = tile_at(t.layer, t.tile_x, t.tile_y);
        r.solid      = 1'b0;
        pending_reads.push_back(r);
      end
      tcl_pkg::KIND_QUERY: begin
        r.tile_value = tile_at(tcl_pkg::MAIN_LAYER, t.pixel_x / tcl_pkg::TILE_W,
                               t.pixel_y / tcl_pkg::TILE_H);
        bitpos       = (t.pixel_x % tcl_pkg::TILE_W)
                     + (t.pixel_y % tcl_pkg::TILE_H) * tcl_pkg::TILE_W;
        mbyte        = mask_mem[r.tile_value * tcl_pkg::MASK_BYTES + bitpos / 8];
        r.solid      = mbyte[7 - bitpos % 8];
        pending_reads.push_back(r);
      end
      tcl_pkg::KIND_MASK: begin
        if (t.mask_index < tcl_pkg::MASK_BYTES)
          mask_mem[t.mask_tile * tcl_pkg::MASK_BYTES + t.mask_index] = t.value;
      end
    endcase
  endfunction

  always @(posedge clk) begin
    tcl_pkg::out_t want;
    if (rst_n && out_valid) begin
      if (pending_reads.size() == 0) begin
        $error("unexpected result: tile_value %0d solid %0d",
               out_data.tile_value, out_data.solid);
        fault_count++;
      end else begin
        want = pending_reads.pop_front();
        if (out_data.tile_value !== want.tile_value) begin
          $error("tile_value: expected %0d, actual %0d", want.tile_value,
                 out_data.tile_value);
          fault_count++;
        end
        if (out_data.solid !== want.solid) begin
          $error("solid: expected %0d, actual %0d", want.solid, out_data.solid);
          fault_count++;
        end
      end
    end
  end

  task automatic send_item(input tcl_pkg::in_t t);
    if (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (busy);
    map_apply(t);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [tcl_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tcl_pkg::CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      tcl_pkg::CFG_WRAP: wrap_mask = data[tcl_pkg::WRAP_W-1:0];
      CFG_UNUSED:        ;
      default:           layer_size[idx] = data;
    endcase
  endtask

  task automatic apply_cfg(input int unsigned l0w, l0h, l1w, l1h, l2w, l2h,
                           input logic [tcl_pkg::WRAP_W-1:0] wrap);
    logic [5:0][tcl_pkg::CFG_W-1:0] sizes;
    sizes = {tcl_pkg::CFG_W'(l2h), tcl_pkg::CFG_W'(l2w), tcl_pkg::CFG_W'(l1h),
             tcl_pkg::CFG_W'(l1w), tcl_pkg::CFG_W'(l0h), tcl_pkg::CFG_W'(l0w)};
    drain();
    for (int i = tcl_pkg::CFG_L0_W; i <= tcl_pkg::CFG_L2_H; i++)
      write_reg(tcl_pkg::CFG_IDX_W'(i), sizes[i]);
    write_reg(tcl_pkg::CFG_WRAP, {4'($urandom), wrap});
    write_reg(CFG_UNUSED, tcl_pkg::CFG_W'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic tcl_pkg::in_t noise_item();
    tcl_pkg::in_t t;
    t.kind       = tcl_pkg::kind_t'($urandom_range(3));
    t.layer      = tcl_pkg::LAYER_W'($urandom);
    t.tile_x     = tcl_pkg::CRD_W'($urandom);
    t.tile_y     = tcl_pkg::CRD_W'($urandom);
    t.pixel_x    = tcl_pkg::PIX_W'($urandom);
    t.pixel_y    = tcl_pkg::PIX_W'($urandom);
    t.value      = tcl_pkg::BYTE_W'($urandom);
    t.mask_tile  = tcl_pkg::BYTE_W'($urandom);
    t.mask_index = tcl_pkg::MIDX_W'($urandom);
    return t;
  endfunction

  function automatic tcl_pkg::in_t tile_op(tcl_pkg::kind_t k, int unsigned lyr,
                                           int unsigned x, int unsigned y,
                                           int unsigned v);
    tcl_pkg::in_t t;
    t        = noise_item();
    t.kind   = k;
    t.layer  = tcl_pkg::LAYER_W'(lyr);
    t.tile_x = tcl_pkg::CRD_W'(x);
    t.tile_y = tcl_pkg::CRD_W'(y);
    t.value  = tcl_pkg::BYTE_W'(v);
    return t;
  endfunction

  function automatic tcl_pkg::in_t pixel_op(int unsigned px, int unsigned py);
    tcl_pkg::in_t t;
    t         = noise_item();
    t.kind    = tcl_pkg::KIND_QUERY;
    t.pixel_x = tcl_pkg::PIX_W'(px);
    t.pixel_y = tcl_pkg::PIX_W'(py);
    return t;
  endfunction

  function automatic tcl_pkg::in_t mask_op(int unsigned tile, int unsigned idx,
                                           int unsigned v);
    tcl_pkg::in_t t;
    t            = noise_item();
    t.kind       = tcl_pkg::KIND_MASK;
    t.mask_tile  = tcl_pkg::BYTE_W'(tile);
    t.mask_index = tcl_pkg::MIDX_W'(idx);
    t.value      = tcl_pkg::BYTE_W'(v);
    return t;
  endfunction

  function automatic tcl_pkg::in_t random_item();
    tcl_pkg::in_t t;
    int unsigned  pick;
    t    = noise_item();
    pick = $urandom_range(99);
    t.kind = (pick < 30) ? tcl_pkg::KIND_SET : (pick < 55) ? tcl_pkg::KIND_GET :
             (pick < 85) ? tcl_pkg::KIND_QUERY : tcl_pkg::KIND_MASK;
    if ($urandom_range(99) < 75) begin
      t.tile_x  = tcl_pkg::CRD_W'($urandom_range(0, 70));
      t.tile_y  = tcl_pkg::CRD_W'($urandom_range(0, 70));
      t.pixel_x = tcl_pkg::PIX_W'($urandom_range(0, 1100));
      t.pixel_y = tcl_pkg::PIX_W'($urandom_range(0, 1100));
    end
    if (t.kind == tcl_pkg::KIND_SET && $urandom_range(99) < 40)
      t.layer = tcl_pkg::LAYER_W'(tcl_pkg::MAIN_LAYER);
    if ($urandom_range(99) < 50) t.value = tcl_pkg::BYTE_W'($urandom_range(0, 7));
    if ($urandom_range(99) < 60) t.mask_tile = tcl_pkg::BYTE_W'($urandom_range(0, 7));
    return t;
  endfunction

  function automatic int unsigned random_size();
    case ($urandom_range(9))
      0:       return 0;
      1:       return 1;
      2:       return tcl_pkg::MAX_DIM;
      3:       return 'h7F;
      default: return $urandom_range(2, 80);
    endcase
  endfunction

  task automatic test_tile_edges();
    send_item(tile_op(tcl_pkg::KIND_GET, 0, 0, 0, 0));
    send_item(tile_op(tcl_pkg::KIND_SET, 0, tcl_pkg::MAX_DIM - 1, tcl_pkg::MAX_DIM - 1,
                      8'hFF));
    send_item(tile_op(tcl_pkg::KIND_GET, 0, tcl_pkg::MAX_DIM - 1, tcl_pkg::MAX_DIM - 1, 0));
    send_item(tile_op(tcl_pkg::KIND_GET, 0, tcl_pkg::MAX_DIM, tcl_pkg::MAX_DIM - 1, 0));
    send_item(tile_op(tcl_pkg::KIND_SET, 2, 16'hFFFF, 16'hFFFF, 8'hAA));
    send_item(tile_op(tcl_pkg::KIND_GET, 2, 16'hFFFF, 16'hFFFF, 0));
  endtask

  task automatic test_absent_layer();
    send_item(tile_op(tcl_pkg::KIND_SET, 3, 0, 0, 8'h55));
    send_item(tile_op(tcl_pkg::KIND_GET, 3, 0, 0, 0));
  endtask

  task automatic test_mask_bits();
    send_item(pixel_op(0, 0));
    send_item(tile_op(tcl_pkg::KIND_SET, tcl_pkg::MAIN_LAYER, 0, 0, 5));
    send_item(mask_op(5, 0, 8'h80));
    send_item(pixel_op(0, 0));
    send_item(pixel_op(1, 0));
    send_item(tile_op(tcl_pkg::KIND_SET, tcl_pkg::MAIN_LAYER, 1, 1, 8'hFF));
    send_item(mask_op(8'hFF, tcl_pkg::MASK_BYTES - 1, 8'h01));
    send_item(pixel_op(2 * tcl_pkg::TILE_W - 1, 2 * tcl_pkg::TILE_H - 1));
    send_item(pixel_op(2 * tcl_pkg::TILE_W - 2, 2 * tcl_pkg::TILE_H - 1));
    send_item(pixel_op(20'hFFFFF, 20'hFFFFF));
  endtask

  task automatic test_wrap_reads();
    apply_cfg(3, 5, 'h7F, 1, 0, tcl_pkg::MAX_DIM, 3'b111);
    send_item(tile_op(tcl_pkg::KIND_SET, 0, 0, 0, 8'h11));
    send_item(tile_op(tcl_pkg::KIND_GET, 0, 16'hFFFF, 16'hFFFF, 0));
    send_item(tile_op(tcl_pkg::KIND_GET, 2, 5, 5, 0));
    send_item(pixel_op(20'hFFFFF, tcl_pkg::TILE_H));
  endtask

  task automatic test_resize_keeps_tiles();
    apply_cfg(1, 1, tcl_pkg::MAX_DIM, tcl_pkg::MAX_DIM, tcl_pkg::MAX_DIM, tcl_pkg::MAX_DIM,
              3'b000);
    send_item(tile_op(tcl_pkg::KIND_GET, 0, tcl_pkg::MAX_DIM - 1, tcl_pkg::MAX_DIM - 1, 0));
    apply_cfg(tcl_pkg::MAX_DIM, tcl_pkg::MAX_DIM, tcl_pkg::MAX_DIM, tcl_pkg::MAX_DIM,
              tcl_pkg::MAX_DIM, tcl_pkg::MAX_DIM, 3'b000);
    send_item(tile_op(tcl_pkg::KIND_GET, 0, tcl_pkg::MAX_DIM - 1, tcl_pkg::MAX_DIM - 1, 0));
  endtask

  task automatic test_random_traffic();
    int unsigned fill;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       apply_cfg(tcl_pkg::MAX_DIM, tcl_pkg::MAX_DIM, tcl_pkg::MAX_DIM,
                           tcl_pkg::MAX_DIM, tcl_pkg::MAX_DIM, tcl_pkg::MAX_DIM, 3'b000);
        1:       apply_cfg('h7F, 'h7F, 'h7F, 'h7F, 'h7F, 'h7F, 3'b111);
        2:       apply_cfg(1, 1, 1, 1, 1, 1, 3'b111);
        3:       apply_cfg(0, 0, 0, 0, 0, 0, 3'b111);
        default: begin
          fill = random_size();
          apply_cfg(random_size(), random_size(), fill, random_size(), random_size(),
                    random_size(), tcl_pkg::WRAP_W'($urandom));
        end
      endcase
      no_gaps = (p == QUIET_PHASE);
      repeat (PHASE_ITEMS) send_item(random_item());
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < tcl_pkg::TILE_DEPTH; i++) tile_mem[i] = '0;
    for (int i = 0; i < tcl_pkg::MASK_DEPTH; i++)
      mask_mem[i] = (i < tcl_pkg::MASK_BYTES) ? 8'h00 : 8'hFF;
    for (int i = 0; i < 6; i++) layer_size[i] = tcl_pkg::CFG_W'(tcl_pkg::MAX_DIM);
    wrap_mask = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk); while (busy);
    test_tile_edges();
    test_absent_layer();
    test_mask_bits();
    test_wrap_reads();
    test_resize_keeps_tiles();
    test_random_traffic();
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
